// ----- hdl/cdsd_pkg.sv -----
// Package with the shared constants, codes and command type of the card deck block.
`timescale 1ns / 1ps
package cdsd_pkg;

  // Deck size and the widths that follow from it.
  localparam int DECK_CARDS = 52;
  localparam int IDX_W      = $clog2(DECK_CARDS);
  localparam int TOP_W      = $clog2(DECK_CARDS + 1);
  localparam int CARD_W     = 6;
  localparam int FIELD_W    = 6;
  localparam int ACT_W      = 3;
  localparam int SUM_W      = 9;

  // Action codes as they arrive on the input channel.
  localparam logic [ACT_W-1:0] ACT_INIT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SWAP = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DRAW = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CUT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEAL = 3'd4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_PICK = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Decoded operations.
  typedef enum logic [2:0] {
    OP_INIT,
    OP_SWAP,
    OP_DRAW,
    OP_CUT,
    OP_DEAL,
    OP_NOP
  } op_t;

  // One decoded item as it travels from the front end to the back end.
  typedef struct packed {
    op_t                op;
    logic [FIELD_W-1:0] pick;
    logic [FIELD_W-1:0] offset_a;
    logic [FIELD_W-1:0] offset_b;
    status_t            deal_status;
    logic [IDX_W-1:0]   deal_idx;
  } cmd_t;

endpackage

// ----- hdl/cdsd_in_if.sv -----
// Input channel interface: handshake plus the fields of one input item.
`timescale 1ns / 1ps
interface cdsd_in_if;
  import cdsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [FIELD_W-1:0] pick;
  logic [FIELD_W-1:0] offset_a;
  logic [FIELD_W-1:0] offset_b;

  modport source (output valid, action, pick, offset_a, offset_b, input ready);
  modport sink (input valid, action, pick, offset_a, offset_b, output ready);
endinterface

// ----- hdl/cdsd_out_if.sv -----
// Result channel interface: handshake plus the fields of one result item.
`timescale 1ns / 1ps
interface cdsd_out_if;
  import cdsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CARD_W-1:0] card;
  logic [1:0]        status;
  logic              shuffle_done;

  modport source (output valid, card, status, shuffle_done, input ready);
  modport sink (input valid, card, status, shuffle_done, output ready);
endinterface

// ----- hdl/cdsd_front.sv -----
// Front end: decodes each input item into a command and checks the deal cut range.
`timescale 1ns / 1ps
module cdsd_front
  import cdsd_pkg::*;
(
  cdsd_in_if.sink in_if,
  output logic    cmd_valid,
  input  logic    cmd_ready,
  output cmd_t    cmd
);

  logic [FIELD_W:0] deal_sum;

  assign cmd_valid   = in_if.valid;
  assign in_if.ready = cmd_ready;

  // Deal cut needs no deck state, so its range checks are settled here.
  assign deal_sum = {1'b0, in_if.pick} + {1'b0, in_if.offset_a};

  always_comb begin
    cmd.pick        = in_if.pick;
    cmd.offset_a    = in_if.offset_a;
    cmd.offset_b    = in_if.offset_b;
    cmd.deal_idx    = deal_sum[IDX_W-1:0];
    cmd.deal_status = ST_OK;
    // The span offset_b - offset_a must be positive and exceed the pick.
    if (deal_sum >= {1'b0, in_if.offset_b}) begin
      cmd.deal_status = ST_PICK;
    end else if (deal_sum >= (FIELD_W+1)'(DECK_CARDS)) begin
      cmd.deal_status = ST_BAD;
    end

    case (in_if.action)
      ACT_INIT: cmd.op = OP_INIT;
      ACT_SWAP: cmd.op = OP_SWAP;
      ACT_DRAW: cmd.op = OP_DRAW;
      ACT_CUT:  cmd.op = OP_CUT;
      ACT_DEAL: cmd.op = OP_DEAL;
      default:  cmd.op = OP_NOP;
    endcase
  end

endmodule

// ----- hdl/cdsd_queue.sv -----
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
module cdsd_queue
  import cdsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- hdl/cdsd_back.sv -----
// Back end: deck store, top pointer, swap position and the result register.
`timescale 1ns / 1ps
module cdsd_back
  import cdsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  cdsd_out_if.source out_if
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_WR_A = 5'b00100,
    S_WR_B = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [TOP_W-1:0]   top_r, top_nxt;
  logic [FIELD_W-1:0] pos_r, pos_nxt;
  logic [DECK_CARDS-1:0] vld_r;

  // Pending result and the output register.
  logic [CARD_W-1:0] res_card_r, res_card_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              res_done_r, res_done_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CARD_W-1:0] out_card_r;
  status_t           out_status_r;
  logic              out_done_r;

  // Store ports.
  logic [CARD_W-1:0] mem [DECK_CARDS];
  logic              rd_en;
  logic [IDX_W-1:0]  ra0, ra1;
  logic [IDX_W-1:0]  ra0_r, ra1_r;
  logic [CARD_W-1:0] rd0_r, rd1_r;
  logic              vld0_r, vld1_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [CARD_W-1:0] mem_wd;
  logic              vld_clear;
  logic [CARD_W-1:0] val0, val1;

  // Cut arithmetic.
  logic [SUM_W-1:0] cut_sum;
  logic [SUM_W-1:0] cut_base;
  logic [SUM_W-1:0] cut_idx;
  logic             load_out;

  // An entry never written since init holds its own index.
  assign val0 = vld0_r ? rd0_r : CARD_W'(ra0_r);
  assign val1 = vld1_r ? rd1_r : CARD_W'(ra1_r);

  assign cut_sum  = SUM_W'(top_r) + SUM_W'(cmd.offset_a) + SUM_W'(cmd.offset_b);
  assign cut_base = SUM_W'(top_r) + SUM_W'(cmd.offset_a) + SUM_W'(cmd.pick);
  assign cut_idx  = cut_base - SUM_W'(1);

  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_if.ready);
  assign cmd_ready = (state_r == S_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    top_nxt        = top_r;
    pos_nxt        = pos_r;
    res_card_nxt   = res_card_r;
    res_status_nxt = res_status_r;
    res_done_nxt   = res_done_r;
    out_valid_nxt  = out_valid_r;
    rd_en          = 1'b0;
    ra0            = '0;
    ra1            = '0;
    mem_we         = 1'b0;
    mem_wa         = ra0_r;
    mem_wd         = val1;
    vld_clear      = 1'b0;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          op_nxt         = cmd.op;
          res_card_nxt   = '0;
          res_status_nxt = ST_OK;
          res_done_nxt   = 1'b0;
          state_nxt      = S_DONE;
          case (cmd.op)
            OP_INIT: begin
              vld_clear = 1'b1;
              top_nxt   = '0;
              pos_nxt   = FIELD_W'(DECK_CARDS - 1);
            end
            OP_SWAP: begin
              if (cmd.pick > pos_r) begin
                res_status_nxt = ST_PICK;
              end else begin
                rd_en     = 1'b1;
                ra0       = pos_r[IDX_W-1:0];
                ra1       = cmd.pick[IDX_W-1:0];
                state_nxt = S_READ;
              end
            end
            OP_DRAW: begin
              if (top_r >= TOP_W'(DECK_CARDS)) begin
                res_status_nxt = ST_BAD;
              end else begin
                rd_en     = 1'b1;
                ra0       = top_r[IDX_W-1:0];
                state_nxt = S_READ;
              end
            end
            OP_CUT: begin
              // The sum of top, both offsets and the pick must stay below the deck size.
              if ((cut_sum >= SUM_W'(DECK_CARDS)) ||
                  (cut_sum + SUM_W'(cmd.pick) >= SUM_W'(DECK_CARDS))) begin
                res_status_nxt = ST_PICK;
              end else if (cut_base == '0) begin
                res_status_nxt = ST_BAD;
              end else begin
                rd_en     = 1'b1;
                ra0       = cut_idx[IDX_W-1:0];
                state_nxt = S_READ;
              end
            end
            OP_DEAL: begin
              if (cmd.deal_status != ST_OK) begin
                res_status_nxt = cmd.deal_status;
              end else begin
                rd_en     = 1'b1;
                ra0       = cmd.deal_idx;
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (op_r == OP_SWAP) begin
          state_nxt = S_WR_A;
        end else begin
          res_card_nxt = val0;
          if (op_r == OP_DRAW) begin
            top_nxt = top_r + TOP_W'(1);
          end
          state_nxt = S_DONE;
        end
      end
      S_WR_A: begin
        // Position entry takes the picked card.
        mem_we    = 1'b1;
        mem_wa    = ra0_r;
        mem_wd    = val1;
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        // Picked entry takes the old position card; then advance the shuffle.
        mem_we = 1'b1;
        mem_wa = ra1_r;
        mem_wd = val0;
        if (pos_r <= FIELD_W'(1)) begin
          res_done_nxt = 1'b1;
          top_nxt      = '0;
          pos_nxt      = FIELD_W'(DECK_CARDS - 1);
        end else begin
          pos_nxt = pos_r - FIELD_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_NOP;
      top_r       <= '0;
      pos_r       <= FIELD_W'(DECK_CARDS - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      top_r       <= top_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Written flags: a cleared flag makes an entry read as identity order.
  always_ff @(posedge clk) begin
    if (!rst_n || vld_clear) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_wa] <= 1'b1;
    end
  end

  // Pending result and output register payload.
  always_ff @(posedge clk) begin
    res_card_r   <= res_card_nxt;
    res_status_r <= res_status_nxt;
    res_done_r   <= res_done_nxt;
    if (load_out) begin
      out_card_r   <= res_card_r;
      out_status_r <= res_status_r;
      out_done_r   <= res_done_r;
    end
  end

  // Deck store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd0_r  <= mem[ra0];
      rd1_r  <= mem[ra1];
      vld0_r <= vld_r[ra0];
      vld1_r <= vld_r[ra1];
      ra0_r  <= ra0;
      ra1_r  <= ra1;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.card         = out_card_r;
  assign out_if.status       = out_status_r;
  assign out_if.shuffle_done = out_done_r;

endmodule

// ----- hdl/card_deck_shuffle_draw_cut.sv -----
// Top level of the card deck store with stepwise shuffle, draw and cut.
//
//   channel  | direction | handshake          | fields
//   in_if    | input     | valid/ready        | action, pick, offset_a, offset_b
//   out_if   | output    | valid/ready        | card, status, shuffle_done
//
// A shuffle swap, once out of the queue, reads both entries, writes them back one
// per cycle on the single write port, then loads the output. Draw, cut and deal
// cut read one entry, then load the output; init, rejected items and unknown
// actions go straight to the output load. Reset is synchronous and leaves the
// deck in identity order at once through per-entry written flags. A two-entry
// queue keeps taking items while the back end works or waits on a stalled output register.
`timescale 1ns / 1ps
module card_deck_shuffle_draw_cut
  import cdsd_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  cdsd_in_if.sink     in_if,
  cdsd_out_if.source  out_if
);

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  // Decode items as they arrive.
  cdsd_front u_front (
    .in_if     (in_if),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // Decouple the decoder from the deck sequencer.
  cdsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  // Carry out each command on the deck.
  cdsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .out_if    (out_if)
  );

endmodule
